@@ sv/aiu_pkg.sv @@
// shared types and constants for the unique array intersection block
package aiu_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned MaxElemsDef = 32;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_RUN    = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [WordW-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [WordW-1:0] common_value;
    logic                    last;
    logic                    no_common;
    logic                    overflow;
  } res_t;

endpackage

@@ sv/aiu_if.sv @@
// valid/ready channel interfaces for input and result beats
interface aiu_in_if;
  import aiu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FuncW-1:0]        func;
  logic signed [WordW-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface aiu_out_if;
  import aiu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] common_value;
  logic                    last;
  logic                    no_common;
  logic                    overflow;

  modport source (output valid, output common_value, output last, output no_common,
                  output overflow, input ready);
  modport sink   (input valid, input common_value, input last, input no_common,
                  input overflow, output ready);
endinterface

@@ sv/aiu_ram.sv @@
// generic simple dual-port ram with registered read
module aiu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/aiu_seq.sv @@
// list stores and the sequencer that walks them with one shared comparator
module aiu_seq #(
  parameter int unsigned MaxElems = aiu_pkg::MaxElemsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  aiu_pkg::in_beat_t in_beat_i,
  input  logic             out_free_i,
  output logic             push_o,
  output aiu_pkg::res_t    res_o
);
  import aiu_pkg::*;

  localparam int unsigned AW = (MaxElems > 1) ? $clog2(MaxElems) : 1;
  localparam int unsigned CW = $clog2(MaxElems + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_A_REQ  = 10'b0000000010,
    S_A_WAIT = 10'b0000000100,
    S_B_REQ  = 10'b0000001000,
    S_B_CMP  = 10'b0000010000,
    S_F_REQ  = 10'b0000100000,
    S_F_CMP  = 10'b0001000000,
    S_O_REQ  = 10'b0010000000,
    S_O_WAIT = 10'b0100000000,
    S_UNUSED = 10'b1000000000
  } state_e;

  state_e           st_q, st_d;
  logic [CW-1:0]    cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0]    i_q, i_d, j_q, j_d, k_q, k_d, nf_q, nf_d;
  logic             ovf_q, ovf_d;
  logic [WordW-1:0] a_val_q, a_val_d;

  logic             a_we, b_we, f_we, a_re, b_re, f_re;
  logic [AW-1:0]    f_raddr;
  logic [WordW-1:0] a_rdata, b_rdata, f_rdata, cmp_word;
  logic             words_eq, accept;

  aiu_ram #(.Width(WordW), .Depth(MaxElems), .AddrW(AW)) u_ram_a (
    .clk_i, .we_i(a_we), .waddr_i(cnt_a_q[AW-1:0]), .wdata_i(in_beat_i.value),
    .re_i(a_re), .raddr_i(i_q[AW-1:0]), .rdata_o(a_rdata)
  );

  aiu_ram #(.Width(WordW), .Depth(MaxElems), .AddrW(AW)) u_ram_b (
    .clk_i, .we_i(b_we), .waddr_i(cnt_b_q[AW-1:0]), .wdata_i(in_beat_i.value),
    .re_i(b_re), .raddr_i(j_q[AW-1:0]), .rdata_o(b_rdata)
  );

  aiu_ram #(.Width(WordW), .Depth(MaxElems), .AddrW(AW)) u_ram_f (
    .clk_i, .we_i(f_we), .waddr_i(nf_q[AW-1:0]), .wdata_i(a_val_q),
    .re_i(f_re), .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  // the one shared compare unit
  assign cmp_word = (st_q == S_F_CMP) ? f_rdata : b_rdata;
  assign words_eq = (a_val_q == cmp_word);

  assign in_ready_o = (st_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign f_raddr    = k_q[AW-1:0];

  always_comb begin
    st_d    = st_q;
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    nf_d    = nf_q;
    ovf_d   = ovf_q;
    a_val_d = a_val_q;
    a_we    = 1'b0;
    b_we    = 1'b0;
    f_we    = 1'b0;
    a_re    = 1'b0;
    b_re    = 1'b0;
    f_re    = 1'b0;
    push_o  = 1'b0;
    res_o   = '{common_value: f_rdata, last: (CW'(k_q + 1'b1) == nf_q),
                no_common: 1'b0, overflow: ovf_q};

    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func_e'(in_beat_i.func))
            FUNC_LOAD_A: begin
              if (cnt_a_q < CW'(MaxElems)) begin
                a_we    = 1'b1;
                cnt_a_d = CW'(cnt_a_q + 1'b1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            FUNC_LOAD_B: begin
              if (cnt_b_q < CW'(MaxElems)) begin
                b_we    = 1'b1;
                cnt_b_d = CW'(cnt_b_q + 1'b1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            FUNC_RUN: begin
              i_d  = '0;
              nf_d = '0;
              st_d = S_A_REQ;
            end
            default: ;
          endcase
        end
      end
      S_A_REQ: begin
        if (i_q == cnt_a_q) begin
          k_d  = '0;
          st_d = S_O_REQ;
        end else begin
          a_re = 1'b1;
          st_d = S_A_WAIT;
        end
      end
      S_A_WAIT: begin
        a_val_d = a_rdata;
        j_d     = '0;
        st_d    = S_B_REQ;
      end
      S_B_REQ: begin
        if (j_q == cnt_b_q) begin
          i_d  = CW'(i_q + 1'b1);
          st_d = S_A_REQ;
        end else begin
          b_re = 1'b1;
          st_d = S_B_CMP;
        end
      end
      S_B_CMP: begin
        if (words_eq) begin
          k_d  = '0;
          st_d = S_F_REQ;
        end else begin
          j_d  = CW'(j_q + 1'b1);
          st_d = S_B_REQ;
        end
      end
      S_F_REQ: begin
        if (k_q == nf_q) begin
          f_we = 1'b1;
          nf_d = CW'(nf_q + 1'b1);
          i_d  = CW'(i_q + 1'b1);
          st_d = S_A_REQ;
        end else begin
          f_re = 1'b1;
          st_d = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (words_eq) begin
          i_d  = CW'(i_q + 1'b1);
          st_d = S_A_REQ;
        end else begin
          k_d  = CW'(k_q + 1'b1);
          st_d = S_F_REQ;
        end
      end
      S_O_REQ: begin
        if (nf_q == '0) begin
          res_o = '{common_value: '0, last: 1'b1, no_common: 1'b1, overflow: ovf_q};
          if (out_free_i) begin
            push_o  = 1'b1;
            cnt_a_d = '0;
            cnt_b_d = '0;
            ovf_d   = 1'b0;
            st_d    = S_IDLE;
          end
        end else begin
          f_re = 1'b1;
          st_d = S_O_WAIT;
        end
      end
      S_O_WAIT: begin
        if (out_free_i) begin
          push_o = 1'b1;
          if (res_o.last) begin
            cnt_a_d = '0;
            cnt_b_d = '0;
            ovf_d   = 1'b0;
            st_d    = S_IDLE;
          end else begin
            k_d  = CW'(k_q + 1'b1);
            st_d = S_O_REQ;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      nf_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      nf_q    <= nf_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_val_q <= a_val_d;
  end

endmodule

@@ sv/array_intersection_unique.sv @@
// load beats fill the A or B store; func 3 beats do nothing
// a run walks every A word against B and, on a match, against the found list,
// using the one shared comparator, then emits each found word as one result;
// output stalls can hold the run while it emits results
// results sit in an output register, so loads are taken while the last one waits
// reset clears list counts, overflow flag and output valid; stores are not cleared
module array_intersection_unique #(
  parameter int unsigned MaxElems = aiu_pkg::MaxElemsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aiu_in_if.sink    in_i,
  aiu_out_if.source out_o
);
  import aiu_pkg::*;

  in_beat_t in_beat;
  res_t     res, res_q;
  logic     push, out_free, out_valid_q;

  assign in_beat  = '{func: in_i.func, value: in_i.value};
  assign out_free = !out_valid_q || out_o.ready;

  aiu_seq #(.MaxElems(MaxElems)) u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_beat_i  (in_beat),
    .out_free_i (out_free),
    .push_o     (push),
    .res_o      (res)
  );

  // result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && out_free) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.common_value = res_q.common_value;
  assign out_o.last         = res_q.last;
  assign out_o.no_common    = res_q.no_common;
  assign out_o.overflow     = res_q.overflow;

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for array_intersection_unique: directed table, random load/run batches
`timescale 1ns / 100ps

module tb_top;
  import aiu_pkg::*;

  localparam int unsigned Cap         = MaxElemsDef;
  localparam int unsigned RandItems   = 96;
  localparam int unsigned DrainCycles = 64;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct {
    func_e func;
    word_t value;
    bit    typed;
    res_t  want;
  } step_t;

  localparam res_t NoneRes = '{common_value: '0, last: 1'b1, no_common: 1'b1, overflow: 1'b0};
  localparam res_t NegTwoRes = '{common_value: -32'sd2, last: 1'b1, no_common: 1'b0,
                                 overflow: 1'b0};

  step_t dir_tbl [23] = '{
    '{FUNC_RUN,    32'h0000_0000, 1'b1, NoneRes},
    '{FUNC_LOAD_A, 32'h0000_0005, 1'b0, '0},
    '{FUNC_RUN,    32'h0000_0000, 1'b1, NoneRes},
    '{FUNC_LOAD_B, 32'h0000_0005, 1'b0, '0},
    '{FUNC_RUN,    32'hffff_ffff, 1'b1, NoneRes},
    '{FUNC_LOAD_A, 32'h7fff_ffff, 1'b0, '0},
    '{FUNC_LOAD_A, 32'h8000_0000, 1'b0, '0},
    '{FUNC_LOAD_A, 32'hffff_ffff, 1'b0, '0},
    '{FUNC_LOAD_A, 32'h0000_0000, 1'b0, '0},
    '{FUNC_LOAD_A, 32'h7fff_ffff, 1'b0, '0},
    '{FUNC_NOP,    32'h1234_5678, 1'b0, '0},
    '{FUNC_LOAD_B, 32'h0000_0000, 1'b0, '0},
    '{FUNC_LOAD_B, 32'h8000_0000, 1'b0, '0},
    '{FUNC_LOAD_B, 32'h7fff_ffff, 1'b0, '0},
    '{FUNC_LOAD_B, 32'h7fff_ffff, 1'b0, '0},
    '{FUNC_RUN,    32'h5555_5555, 1'b0, '0},
    '{FUNC_LOAD_A, 32'h0000_0001, 1'b0, '0},
    '{FUNC_LOAD_B, 32'h0000_0002, 1'b0, '0},
    '{FUNC_NOP,    32'h0000_0001, 1'b0, '0},
    '{FUNC_RUN,    32'haaaa_aaaa, 1'b1, NoneRes},
    '{FUNC_LOAD_A, 32'hffff_fffe, 1'b0, '0},
    '{FUNC_LOAD_B, 32'hffff_fffe, 1'b0, '0},
    '{FUNC_RUN,    32'h0000_0000, 1'b1, NegTwoRes}
  };

  logic clk_i;
  logic rst_ni;

  aiu_in_if  in_if ();
  aiu_out_if out_if ();

  array_intersection_unique #(
    .MaxElems(Cap)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  word_t       list_a [$];
  word_t       list_b [$];
  bit          dropped;
  res_t        run_res [$];
  res_t        expected_res [$];
  int unsigned errors;
  int unsigned item_count;
  int          in_quiet;
  int          out_quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("array_intersection_unique regression: fail");
    $finish;
  end

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit holds_word(word_t q [$], word_t w);
    foreach (q[k]) begin
      if (q[k] == w) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void intersect_beat(func_e f, word_t v);
    word_t found [$];
    run_res.delete();
    case (f)
      FUNC_LOAD_A: begin
        if (list_a.size() < Cap) list_a.push_back(v);
        else dropped = 1'b1;
      end
      FUNC_LOAD_B: begin
        if (list_b.size() < Cap) list_b.push_back(v);
        else dropped = 1'b1;
      end
      FUNC_RUN: begin
        foreach (list_a[i]) begin
          if (holds_word(list_b, list_a[i]) && !holds_word(found, list_a[i]))
            found.push_back(list_a[i]);
        end
        if (found.size() == 0) begin
          run_res.push_back('{common_value: '0, last: 1'b1, no_common: 1'b1,
                              overflow: dropped});
        end else begin
          foreach (found[i]) begin
            run_res.push_back('{common_value: found[i], last: (i == found.size() - 1),
                                no_common: 1'b0, overflow: dropped});
          end
        end
        list_a.delete();
        list_b.delete();
        dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic word_t fresh_word();
    case ($urandom_range(0, 5))
      1: return $urandom_range(0, 7);
      2: return -$signed({1'b0, 31'($urandom_range(1, 8))});
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(func_e f, word_t v, bit typed = 1'b0, res_t want = '0);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    intersect_beat(f, v);
    if (typed) begin
      expected_res.push_back(want);
    end else begin
      foreach (run_res[i]) expected_res.push_back(run_res[i]);
    end
    if (f != FUNC_NOP) item_count++;
  endtask

  task automatic send_lists(word_t qa [$], word_t qb [$]);
    while (qa.size() + qb.size() > 0) begin
      if ($urandom_range(0, 19) == 0) send_beat(FUNC_NOP, $urandom);
      if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1)))
        send_beat(FUNC_LOAD_A, qa.pop_front());
      else
        send_beat(FUNC_LOAD_B, qb.pop_front());
    end
    send_beat(FUNC_RUN, $urandom);
  endtask

  function automatic void check_field(string name, logic [WordW-1:0] want,
                                      logic [WordW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none got value %h last %b none %b ovf %b",
                 $time, out_if.common_value, out_if.last, out_if.no_common,
                 out_if.overflow);
      end else begin
        want = expected_res.pop_front();
        check_field("common_value", want.common_value, out_if.common_value);
        check_field("last", want.last, out_if.last);
        check_field("no_common", want.no_common, out_if.no_common);
        check_field("overflow", want.overflow, out_if.overflow);
      end
    end
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap(out_quiet);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    word_t pool [$];
    word_t qa [$];
    word_t qb [$];
    word_t base;
    int    kind;
    int    na;
    int    nb;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.func  = FUNC_NOP;
    in_if.value = '0;
    dropped     = 1'b0;
    errors      = 0;
    in_quiet    = 0;
    out_quiet   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i])
      send_beat(dir_tbl[i].func, dir_tbl[i].value, dir_tbl[i].typed, dir_tbl[i].want);

    item_count = 0;
    for (int b = 0; item_count < RandItems; b++) begin
      pool.delete();
      qa.delete();
      qb.delete();
      kind = (b == 0) ? 1 : (($urandom_range(0, 4) == 0) ? 0 : 2);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) send_beat(func_e'($urandom_range(0, 3)), $urandom);
      end else if (kind == 1) begin
        // overfill: consecutive words so a full A list can match everything
        base = $urandom;
        for (int i = 0; i < Cap + 8; i++) pool.push_back(base + i);
        na = $urandom_range(Cap + 1, Cap + 4);
        nb = $urandom_range(Cap + 1, Cap + 4);
        for (int i = 0; i < na; i++) qa.push_back(pool[i]);
        for (int i = 0; i < nb; i++) qb.push_back(pool[i]);
        send_lists(qa, qb);
      end else begin
        repeat ($urandom_range(1, 6)) pool.push_back(fresh_word());
        na = $urandom_range(0, 10);
        nb = $urandom_range(0, 10);
        repeat (na)
          qa.push_back(($urandom_range(0, 7) == 0) ? fresh_word()
                       : pool[$urandom_range(0, pool.size() - 1)]);
        repeat (nb)
          qb.push_back(($urandom_range(0, 7) == 0) ? fresh_word()
                       : pool[$urandom_range(0, pool.size() - 1)]);
        send_lists(qa, qb);
      end
    end
    in_if.valid <= 1'b0;

    while (expected_res.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("array_intersection_unique regression: pass");
    end else begin
      $display("array_intersection_unique regression: fail");
    end
    $finish;
  end

endmodule
